// ----- rtl/nfct_pkg.sv -----
// Shared types and constants for the noise floor channel tracker.
// Used by nfct_div, noise_floor_channel_tracker and its testbench; no dependencies.
package nfct_pkg;

	localparam int AVG_W = 8;
	localparam int CH_IDX_W = 4;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 8;

	typedef enum logic {
		FUNC_SAMPLE = 1'b0,
		FUNC_SELECT = 1'b1
	} func_t;

	localparam logic [CFG_IDX_W-1:0] REG_CHANNELS_IN_USE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DRIFT_MARGIN = 1'b1;

	typedef struct packed {
		logic done;
		logic [AVG_W-1:0] quot;
	} div_res_t;

endpackage

// ----- rtl/nfct_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module nfct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/nfct_div.sv -----
// Division of a window sum magnitude by the constant window size through a
// multiply by its rounded-up reciprocal; the quotient is registered in the cycle
// after start. Depends on nfct_pkg.
module nfct_div #(
	parameter int WINDOW = 8,
	parameter int SW = 11
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [SW-1:0] mag,
	output nfct_pkg::div_res_t res
);
	import nfct_pkg::*;

	localparam int PW = $clog2(WINDOW);
	localparam int SH = SW + PW;
	localparam int RW = SW + 1;
	localparam int PRW = SW + RW;
	// The reciprocal is rounded up; its excess stays below one part in 2**SW,
	// so the quotient is exact for every magnitude that fits in SW bits.
	localparam logic [RW-1:0] RECIP =
		RW'(((64'd1 << SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

	logic done_q;
	logic [AVG_W-1:0] quot_q;
	logic [PRW-1:0] prod;

	assign prod = PRW'(mag) * PRW'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			quot_q <= '0;
		end else begin
			done_q <= start;
			if (start) begin
				quot_q <= prod[SH +: AVG_W];
			end
		end
	end

	assign res.done = done_q;
	assign res.quot = quot_q;

endmodule

// ----- rtl/noise_floor_channel_tracker.sv -----
// Noise floor tracker: per-channel RSSI window averages and best-channel selection.
// Depends on nfct_pkg, nfct_ram and nfct_div.
//
// Usage: requests enter on the s_ stream (tuser = func, tdata = channel index
// and RSSI sample); one result per request leaves on the m_ stream (average,
// selected channel, drift flag). Configuration is to be written through cfg_we,
// cfg_index and cfg_data only while the block is idle; the block does not enforce it.
// A sample request reads the channel record, then the oldest sample of the
// ring, then divides by the window with a registered reciprocal multiply. A
// select request reads one channel average per cycle from the channel memory
// for the n channels scanned (at least channel 0). A sample for a channel beyond
// the channel count answers without reading the memories. One request is in
// flight at a time; s_tready returns as the result is loaded into the output
// register.
// After reset a clearing pass zeroes both memories, one entry per cycle, over
// all CHANNELS * 2**ceil(log2(WINDOW)) sample entries (128 with the defaults);
// s_tready stays low meanwhile. When the receiver stalls, the result waits
// in the output register and the block holds its finished request until it
// drains.
module noise_floor_channel_tracker #(
	parameter int CHANNELS = 16,
	parameter int WINDOW = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [15:0] s_tdata,  // [3:0] channel_index, [11:4] rssi_sample, [15:12] zero
	input  logic [0:0] s_tuser,   // [0] func
	output logic m_tvalid,
	input  logic m_tready,
	output logic [15:0] m_tdata,  // [7:0] average, [11:8] selected_channel, [12] drift
	input  logic cfg_we,
	input  logic [nfct_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nfct_pkg::CFG_DATA_W-1:0] cfg_data
);
	import nfct_pkg::*;

	localparam int CAW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int PW = $clog2(WINDOW);
	localparam int SW = PW + 8;
	localparam int CWW = AVG_W + SW + PW;
	localparam int SAW = CAW + PW;
	localparam int SDEPTH = CHANNELS << PW;
	localparam int NW = 7;
	localparam int CXW = (CAW > CH_IDX_W) ? CAW : CH_IDX_W;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_CHRD, ST_SMRD, ST_DIV, ST_SCAN, ST_SEL, ST_OUT
	} state_t;

	state_t state_q;
	logic [SAW-1:0] clr_addr_q;
	logic [CH_IDX_W-1:0] ch_q;
	logic signed [AVG_W-1:0] rssi_q;
	logic [PW-1:0] ptr_q;
	logic signed [SW-1:0] sum_q;
	logic neg_q;
	logic [4:0] cin_q;
	logic [7:0] margin_q;
	logic [CAW-1:0] cur_q;
	logic signed [AVG_W-1:0] ref_q;
	logic [NW-1:0] scan_q;
	logic [CAW-1:0] best_q;
	logic signed [AVG_W-1:0] bestv_q;
	logic signed [AVG_W-1:0] avg0_q;
	logic signed [AVG_W-1:0] res_avg_q;
	logic res_drift_q;
	logic m_tvalid_q;
	logic [15:0] m_tdata_q;

	logic s_accept;
	logic [CH_IDX_W-1:0] in_ch;
	logic in_ch_ok;
	logic [CAW-1:0] ch_addr;
	logic [CAW-1:0] in_ch_addr;

	logic ch_we, ch_re;
	logic [CAW-1:0] ch_waddr, ch_raddr;
	logic [CWW-1:0] ch_wdata, ch_rdata;
	logic sm_we, sm_re;
	logic [SAW-1:0] sm_waddr, sm_raddr;
	logic [AVG_W-1:0] sm_wdata, sm_rdata;

	logic [PW-1:0] rd_ptr;
	logic signed [SW-1:0] rd_sum;
	logic signed [AVG_W-1:0] rd_avg;
	logic [PW:0] ptr_inc;
	logic [PW-1:0] ptr_next;
	logic signed [SW-1:0] sum_new;
	logic [SW-1:0] sum_mag;
	logic signed [AVG_W-1:0] quot_s;
	logic signed [AVG_W-1:0] avg_new;
	logic signed [AVG_W+1:0] limit;
	logic drift_new;
	logic [NW-1:0] n_eff;
	logic [NW-1:0] scan_nxt;
	logic div_start;
	div_res_t div_res;

	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign in_ch = s_tdata[3:0];
	assign in_ch_ok = {3'b000, in_ch} < NW'(CHANNELS);
	assign in_ch_addr = CAW'(in_ch);
	assign ch_addr = CAW'(ch_q);

	assign rd_ptr = ch_rdata[PW-1:0];
	assign rd_sum = signed'(ch_rdata[PW+SW-1:PW]);
	assign rd_avg = signed'(ch_rdata[CWW-1:PW+SW]);

	assign ptr_inc = {1'b0, rd_ptr} + (PW+1)'(1);
	assign ptr_next = (ptr_inc >= (PW+1)'(WINDOW)) ? '0 : ptr_inc[PW-1:0];

	assign sum_new = sum_q + SW'(rssi_q) - SW'(signed'(sm_rdata));
	assign sum_mag = sum_new[SW-1] ? SW'(-sum_new) : SW'(sum_new);

	assign quot_s = signed'(div_res.quot);
	assign avg_new = neg_q ? -quot_s : quot_s;
	assign limit = (AVG_W+2)'(ref_q) + signed'({2'b00, margin_q});
	assign drift_new = (CXW'(ch_q) == CXW'(cur_q)) && ((AVG_W+2)'(avg_new) > limit);

	assign n_eff = (NW'(cin_q) > NW'(CHANNELS)) ? NW'(CHANNELS) : NW'(cin_q);
	assign scan_nxt = scan_q + NW'(1);

	// Memory port control. Requests are handled one at a time, so a record
	// is never read while its own write-back is still pending.
	always_comb begin
		ch_we = 1'b0;
		ch_waddr = ch_addr;
		ch_wdata = {avg_new, sum_q, ptr_q};
		ch_re = 1'b0;
		ch_raddr = in_ch_addr;
		sm_we = 1'b0;
		sm_waddr = {ch_addr, ptr_q};
		sm_wdata = rssi_q;
		sm_re = 1'b0;
		sm_raddr = {ch_addr, ptr_next};
		div_start = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				sm_we = 1'b1;
				sm_waddr = clr_addr_q;
				sm_wdata = '0;
				ch_we = (clr_addr_q < SAW'(CHANNELS));
				ch_waddr = clr_addr_q[CAW-1:0];
				ch_wdata = '0;
			end
			ST_IDLE: begin
				if (s_accept) begin
					if (func_t'(s_tuser[0]) == FUNC_SELECT) begin
						ch_re = 1'b1;
						ch_raddr = '0;
					end else begin
						ch_re = in_ch_ok;
					end
				end
			end
			ST_CHRD: begin
				sm_re = 1'b1;
			end
			ST_SMRD: begin
				sm_we = 1'b1;
				div_start = 1'b1;
			end
			ST_DIV: begin
				ch_we = div_res.done;
			end
			ST_SCAN: begin
				ch_re = (scan_nxt < n_eff);
				ch_raddr = scan_nxt[CAW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_addr_q <= '0;
			cin_q <= 5'd16;
			margin_q <= 8'd10;
			cur_q <= '0;
			ref_q <= '0;
			m_tvalid_q <= 1'b0;
			ch_q <= '0;
			rssi_q <= '0;
			ptr_q <= '0;
			sum_q <= '0;
			neg_q <= 1'b0;
			scan_q <= '0;
			best_q <= '0;
			bestv_q <= '0;
			avg0_q <= '0;
			res_avg_q <= '0;
			res_drift_q <= 1'b0;
			m_tdata_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CHANNELS_IN_USE: cin_q <= cfg_data[4:0];
					REG_DRIFT_MARGIN: margin_q <= cfg_data;
					default: begin
					end
				endcase
			end
			// In the output state the load below decides the valid flag.
			if (m_tvalid_q && m_tready && state_q != ST_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + SAW'(1);
					if (clr_addr_q == SAW'(SDEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_accept) begin
						ch_q <= in_ch;
						rssi_q <= signed'(s_tdata[11:4]);
						scan_q <= '0;
						best_q <= '0;
						bestv_q <= '0;
						if (func_t'(s_tuser[0]) == FUNC_SELECT) begin
							state_q <= ST_SCAN;
						end else if (in_ch_ok) begin
							state_q <= ST_CHRD;
						end else begin
							res_avg_q <= '0;
							res_drift_q <= 1'b0;
							state_q <= ST_OUT;
						end
					end
				end
				ST_CHRD: begin
					ptr_q <= ptr_next;
					sum_q <= rd_sum;
					state_q <= ST_SMRD;
				end
				ST_SMRD: begin
					sum_q <= sum_new;
					neg_q <= sum_new[SW-1];
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_res.done) begin
						res_avg_q <= avg_new;
						res_drift_q <= drift_new;
						state_q <= ST_OUT;
					end
				end
				ST_SCAN: begin
					// Channel 0 is always read so its average can serve as the
					// reference when no channel goes below zero.
					if (scan_q == '0) begin
						avg0_q <= rd_avg;
					end
					if (scan_q < n_eff && rd_avg < bestv_q) begin
						bestv_q <= rd_avg;
						best_q <= scan_q[CAW-1:0];
					end
					if (scan_nxt < n_eff) begin
						scan_q <= scan_nxt;
					end else begin
						state_q <= ST_SEL;
					end
				end
				ST_SEL: begin
					cur_q <= best_q;
					ref_q <= (bestv_q < 0) ? bestv_q : avg0_q;
					res_avg_q <= (bestv_q < 0) ? bestv_q : avg0_q;
					res_drift_q <= 1'b0;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q <= {3'b000, res_drift_q, CH_IDX_W'(cur_q), res_avg_q};
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	nfct_ram #(
		.WIDTH(CWW),
		.DEPTH(CHANNELS)
	) u_ch_ram (
		.clk(clk),
		.we(ch_we),
		.waddr(ch_waddr),
		.wdata(ch_wdata),
		.re(ch_re),
		.raddr(ch_raddr),
		.rdata(ch_rdata)
	);

	nfct_ram #(
		.WIDTH(AVG_W),
		.DEPTH(SDEPTH)
	) u_sample_ram (
		.clk(clk),
		.we(sm_we),
		.waddr(sm_waddr),
		.wdata(sm_wdata),
		.re(sm_re),
		.raddr(sm_raddr),
		.rdata(sm_rdata)
	);

	nfct_div #(
		.WINDOW(WINDOW),
		.SW(SW)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.mag(sum_mag),
		.res(div_res)
	);

endmodule

// ----- dv/noise_floor_channel_tracker_tb.sv -----
// Self-checking testbench for noise_floor_channel_tracker: per-channel RSSI window averages,
// best-channel selection and drift flags, checked against an in-bench tracker model.
// Depends on nfct_pkg and the noise_floor_channel_tracker RTL only.
`timescale 1ns / 100ps

module noise_floor_channel_tracker_tb;
	import nfct_pkg::*;

	localparam int NUM_CH = 16;
	localparam int WIN_LEN = 8;
	localparam int IDLE_LIMIT = 3000;
	localparam int LONG_HOLD = 400;

	typedef struct packed {
		func_t func;
		logic [3:0] ch;
		logic signed [7:0] rssi;
	} nf_req_t;

	typedef struct packed {
		logic [7:0] average;
		logic [3:0] sel_ch;
		logic drift;
	} nf_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = '0;  // [3:0] channel_index, [11:4] rssi_sample, [15:12] zero
	logic [0:0] s_tuser = '0;   // [0] func
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [15:0] m_tdata;       // [7:0] average, [11:8] selected_channel, [12] drift
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	noise_floor_channel_tracker dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Tracker state mirrored in the bench.
	logic signed [7:0] sample_ring [NUM_CH][WIN_LEN];
	int ring_pos [NUM_CH];
	int win_sum [NUM_CH];
	int chan_avg [NUM_CH];
	int sel_ch;
	int ref_avg;
	int scan_count;
	int margin;

	nf_req_t request_q[$];
	nf_res_t pending_results[$];
	int errors = 0;

	// Stimulus shaping state.
	int level [NUM_CH];
	int hot_ch;

	function automatic nf_res_t track_request(nf_req_t r);
		nf_res_t res;
		int c, p, s, a, n, best, best_val;
		a = 0;
		res.drift = 1'b0;
		if (r.func == FUNC_SAMPLE) begin
			c = int'(r.ch);
			p = (ring_pos[c] == WIN_LEN - 1) ? 0 : ring_pos[c] + 1;
			ring_pos[c] = p;
			s = int'(r.rssi);
			win_sum[c] = win_sum[c] + s - int'(sample_ring[c][p]);
			sample_ring[c][p] = r.rssi;
			a = win_sum[c] / WIN_LEN;
			chan_avg[c] = a;
			if (c == sel_ch && a > ref_avg + margin)
				res.drift = 1'b1;
		end else begin
			n = (scan_count > NUM_CH) ? NUM_CH : scan_count;
			best = 0;
			best_val = 0;
			for (int i = 0; i < n; i++) begin
				if (chan_avg[i] < best_val) begin
					best_val = chan_avg[i];
					best = i;
				end
			end
			sel_ch = best;
			ref_avg = chan_avg[best];
			a = ref_avg;
		end
		res.average = a[7:0];
		res.sel_ch = sel_ch[3:0];
		return res;
	endfunction

	// Sender: bursts of random length separated by random gaps.
	nf_req_t cur_req;
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin : request_driver
		logic give;
		give = 1'b0;
		if (s_tvalid && s_tready)
			pending_results.push_back(track_request(cur_req));
		if (s_tvalid && !s_tready) begin
			give = 1'b1;
		end else if (gap_left > 0) begin
			gap_left--;
		end else if (request_q.size() > 0) begin
			cur_req = request_q.pop_front();
			give = 1'b1;
			if (burst_left <= 1) begin
				burst_left = $urandom_range(1, 24);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			end else begin
				burst_left--;
			end
		end
		s_tvalid <= give;
		s_tdata <= {4'b0000, cur_req.rssi, cur_req.ch};
		s_tuser <= cur_req.func;
	end

	// Receiver: stall pattern chosen by rx_cyc[12:11], plus one long hold-off that
	// lets the block back up and drop s_tready while requests keep coming.
	bit [31:0] rx_cyc = 0;
	int taken = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int stall_left = 0;

	always @(posedge clk) begin : result_sink
		logic rdy;
		rdy = 1'b1;
		if (m_tvalid && m_tready)
			taken++;
		rx_cyc++;
		if (hold_left > 0) begin
			hold_left--;
			rdy = 1'b0;
		end else if (!hold_done && taken >= 500) begin
			hold_done = 1'b1;
			hold_left = LONG_HOLD;
			rdy = 1'b0;
		end else begin
			case (rx_cyc[12:11])
				2'd0: rdy = 1'b1;
				2'd1: rdy = 1'($urandom_range(0, 1));
				2'd2: rdy = (rx_cyc[1:0] == 2'd0);
				default: begin
					if (stall_left > 0) begin
						stall_left--;
						rdy = 1'b0;
					end else if ($urandom_range(0, 7) == 0) begin
						stall_left = $urandom_range(1, 20);
						rdy = 1'b0;
					end
				end
			endcase
		end
		m_tready <= rdy;
	end

	always @(posedge clk) begin : result_monitor
		nf_res_t want;
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing expected: m_tdata=%h", m_tdata);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[7:0] !== want.average) begin
					$error("average: expected %0d, got %0d",
						$signed(want.average), $signed(m_tdata[7:0]));
					errors++;
				end
				if (m_tdata[11:8] !== want.sel_ch) begin
					$error("selected_channel: expected %0d, got %0d",
						want.sel_ch, m_tdata[11:8]);
					errors++;
				end
				if (m_tdata[12] !== want.drift) begin
					$error("drift: expected %0d, got %0d", want.drift, m_tdata[12]);
					errors++;
				end
			end
		end
	end

	int idle_cycles = 0;

	always @(posedge clk) begin : watchdog
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_CHANNELS_IN_USE)
			scan_count = int'(val[4:0]);
		else
			margin = int'(val);
	endtask

	task automatic add_request(func_t f, int c, int v);
		nf_req_t r;
		r.func = f;
		r.ch = c[3:0];
		r.rssi = v[7:0];
		request_q.push_back(r);
	endtask

	task automatic wait_drained();
		while (request_q.size() != 0 || s_tvalid || pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic nf_req_t random_request();
		nf_req_t r;
		int c, v;
		if ($urandom_range(0, 99) < 9) begin
			// Select requests carry junk in the fields the block ignores.
			r.func = FUNC_SELECT;
			r.ch = 4'($urandom_range(0, 15));
			r.rssi = 8'($urandom_range(0, 255));
			return r;
		end
		if ($urandom_range(0, 63) == 0)
			hot_ch = $urandom_range(0, NUM_CH - 1);
		c = ($urandom_range(0, 1) == 1) ? hot_ch : int'($urandom_range(0, NUM_CH - 1));
		if ($urandom_range(0, 39) == 0)
			level[c] = int'($urandom_range(0, 180)) - 140;
		if ($urandom_range(0, 3) == 0)
			v = int'($urandom_range(0, 255)) - 128;
		else
			v = level[c] + int'($urandom_range(0, 12)) - 6;
		if (v > 127)
			v = 127;
		if (v < -128)
			v = -128;
		r.func = FUNC_SAMPLE;
		r.ch = c[3:0];
		r.rssi = v[7:0];
		return r;
	endfunction

	initial begin
		for (int c = 0; c < NUM_CH; c++) begin
			for (int k = 0; k < WIN_LEN; k++)
				sample_ring[c][k] = '0;
			ring_pos[c] = 0;
			win_sum[c] = 0;
			chan_avg[c] = 0;
			level[c] = int'($urandom_range(0, 60)) - 100;
		end
		sel_ch = 0;
		ref_avg = 0;
		scan_count = 16;
		margin = 10;
		hot_ch = 0;
		cur_req = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed requests at reset configuration.
		@(negedge clk);
		add_request(FUNC_SELECT, 0, 0);       // nothing negative yet: channel 0
		add_request(FUNC_SAMPLE, 0, 127);
		add_request(FUNC_SAMPLE, 0, 127);
		add_request(FUNC_SAMPLE, 0, 127);     // selected channel drifts upward
		add_request(FUNC_SAMPLE, 15, -128);
		add_request(FUNC_SAMPLE, 15, -128);
		add_request(FUNC_SAMPLE, 15, -127);   // average truncates toward zero
		add_request(FUNC_SAMPLE, 7, -1);
		add_request(FUNC_SELECT, 15, -128);   // picks the lowest average
		add_request(FUNC_SAMPLE, 15, 127);    // drift on the new selection
		add_request(FUNC_SAMPLE, 15, -60);
		add_request(FUNC_SAMPLE, 3, 127);     // other channel never drifts
		for (int k = 0; k < 9; k++)           // ninth sample wraps the ring
			add_request(FUNC_SAMPLE, 5, (k % 2 == 0) ? 100 - 7 * k : -100 + 3 * k);
		add_request(FUNC_SELECT, 9, 77);
		wait_drained();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_CHANNELS_IN_USE, 8'h00);
					write_reg(REG_DRIFT_MARGIN, 8'h00);
				end
				1: begin
					write_reg(REG_CHANNELS_IN_USE, 8'hFF);
					write_reg(REG_DRIFT_MARGIN, 8'hFF);
				end
				2: begin
					write_reg(REG_CHANNELS_IN_USE, 8'h01);
					write_reg(REG_DRIFT_MARGIN, 8'h01);
				end
				3: begin
					write_reg(REG_CHANNELS_IN_USE, 8'h10);
					write_reg(REG_DRIFT_MARGIN, 8'h0A);
				end
				default: begin
					write_reg(REG_CHANNELS_IN_USE, 8'($urandom_range(0, 255)));
					write_reg(REG_DRIFT_MARGIN, 8'($urandom_range(0, 40)));
				end
			endcase
			@(negedge clk);
			for (int k = 0; k < 197; k++)
				request_q.push_back(random_request());
			wait_drained();
		end

		repeat (30) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
